// File: rtl/core/csc_pkg.sv
// Shared constants, types and register codes for the column-pair score block.
package csc_pkg;

  localparam int unsigned MAX_ROWS   = 8;
  localparam int unsigned SYM_W      = 3;
  localparam int unsigned COL_W      = SYM_W * MAX_ROWS;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned SIM_W      = 8;
  localparam int unsigned TBL_W      = 16 * SIM_W;
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned WGT_W      = 16;
  localparam int unsigned SCORE_W    = 20;
  localparam int unsigned LCNT_W     = $clog2(MAX_ROWS + 1);
  localparam int unsigned LSUM_W     = SIM_W + LCNT_W;
  localparam int unsigned CNT_W      = $clog2(MAX_ROWS * MAX_ROWS + 1);
  localparam int unsigned SUM_W      = SIM_W + CNT_W;
  localparam int unsigned PROD_W     = 2 * PROB_W;
  localparam int unsigned SQ_STEPS   = PROD_W / 2;
  localparam int unsigned ITER       = (SUM_W > SQ_STEPS) ? SUM_W : SQ_STEPS;
  localparam int unsigned REM_W      = CNT_W + 1;
  localparam int unsigned SQR_W      = SQ_STEPS + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIM_LOW   = 3'd0,
    CFG_SIM_HIGH  = 3'd1,
    CFG_WEIGHT    = 3'd2,
    CFG_ROWS_A    = 3'd3,
    CFG_ROWS_B    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                    valid;
    logic [ITER-1:0]         div_n;
    logic [REM_W-1:0]        div_r;
    logic [ITER-1:0]         div_q;
    logic [CNT_W-1:0]        pairs;
    logic                    neg;
    logic [PROD_W-1:0]       sq_v0;
    logic [SQR_W-1:0]        sq_r0;
    logic [SQ_STEPS-1:0]     sq_q0;
    logic [PROD_W-1:0]       sq_v1;
    logic [SQR_W-1:0]        sq_r1;
    logic [SQ_STEPS-1:0]     sq_q1;
  } csc_iter_t;

endpackage

// File: rtl/core/csc_lane.sv
// One row lane: scores one row of column A against every row of column B.
module csc_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [csc_pkg::SYM_W-1:0]     sym_a_i,
  input  logic                          act_a_i,
  input  logic [csc_pkg::COL_W-1:0]     col_b_i,
  input  logic [csc_pkg::MAX_ROWS-1:0]  act_b_i,
  input  logic [csc_pkg::TBL_W-1:0]     sim_i,
  output logic signed [csc_pkg::LSUM_W-1:0] sum_o,
  output logic [csc_pkg::LCNT_W-1:0]    cnt_o
);
  import csc_pkg::*;

  logic signed [LSUM_W-1:0] sum_d;
  logic [LCNT_W-1:0]        cnt_d;

  always_comb begin
    logic [SYM_W-1:0] sb;
    logic [3:0]       idx;
    sum_d = '0;
    cnt_d = '0;
    for (int l = 0; l < MAX_ROWS; l++) begin
      sb  = col_b_i[l*SYM_W +: SYM_W];
      idx = {sym_a_i[1:0], sb[1:0]};
      if (act_a_i && !sym_a_i[2] && act_b_i[l] && !sb[2]) begin
        sum_d = sum_d + LSUM_W'($signed(sim_i[idx*SIM_W +: SIM_W]));
        cnt_d = cnt_d + LCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o <= sum_d;
      cnt_o <= cnt_d;
    end
  end
endmodule

// File: rtl/core/csc_merge.sv
// Merge stage: adds lane sums and counts, splits sum into sign and magnitude.
module csc_merge (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [csc_pkg::LSUM_W-1:0] sum_i [csc_pkg::MAX_ROWS],
  input  logic [csc_pkg::LCNT_W-1:0]    cnt_i [csc_pkg::MAX_ROWS],
  output logic [csc_pkg::ITER-1:0]      mag_o,
  output logic                          neg_o,
  output logic [csc_pkg::CNT_W-1:0]     pairs_o
);
  import csc_pkg::*;

  logic signed [SUM_W-1:0] tot;
  logic [CNT_W-1:0]        cnt;
  logic [SUM_W-1:0]        mag;

  always_comb begin
    tot = '0;
    cnt = '0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      tot = tot + SUM_W'(sum_i[k]);
      cnt = cnt + CNT_W'(cnt_i[k]);
    end
    mag = tot[SUM_W-1] ? SUM_W'(-tot) : SUM_W'(tot);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o   <= ITER'(mag);
      neg_o   <= tot[SUM_W-1];
      pairs_o <= cnt;
    end
  end
endmodule

// File: rtl/core/csc_iter.sv
// Iteration pipeline: one divide bit and one digit of each of the two square roots per stage.
module csc_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  csc_pkg::csc_iter_t in_i,
  output csc_pkg::csc_iter_t out_o
);
  import csc_pkg::*;

  csc_iter_t stg_q [ITER];

  function automatic csc_iter_t step(csc_iter_t s);
    csc_iter_t        o;
    logic [REM_W-1:0] t;
    logic [SQR_W-1:0] t0, t1, tr0, tr1;
    o = s;
    t = {s.div_r[REM_W-2:0], s.div_n[ITER-1]};
    o.div_n = {s.div_n[ITER-2:0], 1'b0};
    if (t >= REM_W'(s.pairs)) begin
      o.div_r = t - REM_W'(s.pairs);
      o.div_q = {s.div_q[ITER-2:0], 1'b1};
    end else begin
      o.div_r = t;
      o.div_q = {s.div_q[ITER-2:0], 1'b0};
    end
    t0  = {s.sq_r0[SQR_W-3:0], s.sq_v0[PROD_W-1 -: 2]};
    tr0 = {s.sq_q0, 2'b01};
    o.sq_v0 = {s.sq_v0[PROD_W-3:0], 2'b00};
    if (t0 >= tr0) begin
      o.sq_r0 = t0 - tr0;
      o.sq_q0 = {s.sq_q0[SQ_STEPS-2:0], 1'b1};
    end else begin
      o.sq_r0 = t0;
      o.sq_q0 = {s.sq_q0[SQ_STEPS-2:0], 1'b0};
    end
    t1  = {s.sq_r1[SQR_W-3:0], s.sq_v1[PROD_W-1 -: 2]};
    tr1 = {s.sq_q1, 2'b01};
    o.sq_v1 = {s.sq_v1[PROD_W-3:0], 2'b00};
    if (t1 >= tr1) begin
      o.sq_r1 = t1 - tr1;
      o.sq_q1 = {s.sq_q1[SQ_STEPS-2:0], 1'b1};
    end else begin
      o.sq_r1 = t1;
      o.sq_q1 = {s.sq_q1[SQ_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ITER; i++) stg_q[i] <= '0;
    end else if (en_i) begin
      stg_q[0] <= step(in_i);
      for (int i = 1; i < ITER; i++) stg_q[i] <= step(stg_q[i-1]);
    end
  end

  assign out_o = stg_q[ITER-1];
endmodule

// File: rtl/core/rna_column_pair_structure_score.sv
// Top level: column-pair score with row lanes, merge, iteration pipeline and output stage.
//
//  channel | signals                                      | direction
//  in      | in_valid_i, in_stall_o, col_*, *_prob_*      | request in
//  out     | out_valid_o, out_stall_i, score_o, pair_count_o | request out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i              | register write
//
// One request per cycle unless stalled; 16 iteration stages set by the
// 32-bit square root, plus lane, merge, multiply and output stages.
// Reset clears valid bits and loads the register defaults.
// The whole pipeline advances unless a result is held and out_stall_i is high.
module rna_column_pair_structure_score (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [csc_pkg::COL_W-1:0]       col_a_i,
  input  logic [csc_pkg::COL_W-1:0]       col_b_i,
  input  logic [csc_pkg::PROB_W-1:0]      up_prob_a_i,
  input  logic [csc_pkg::PROB_W-1:0]      down_prob_a_i,
  input  logic [csc_pkg::PROB_W-1:0]      up_prob_b_i,
  input  logic [csc_pkg::PROB_W-1:0]      down_prob_b_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [csc_pkg::SCORE_W-1:0] score_o,
  output logic [csc_pkg::CNT_W-1:0]       pair_count_o,
  input  logic                            cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [csc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import csc_pkg::*;

  localparam int unsigned RT_W  = SQ_STEPS + 1;
  localparam int unsigned MUL_W = RT_W + WGT_W;
  localparam int unsigned SEQ_W = ITER + 5;
  localparam int unsigned ACC_W = SEQ_W + 1;

  logic [TBL_W-1:0]  sim_q;
  logic [WGT_W-1:0]  wgt_q;
  logic [ROW_W-1:0]  rows_a_q, rows_b_q;
  logic              en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_q    <= '0;
      wgt_q    <= WGT_W'(256);
      rows_a_q <= ROW_W'(1);
      rows_b_q <= ROW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIM_LOW:  sim_q[TBL_W/2-1:0]     <= cfg_data_i[TBL_W/2-1:0];
        CFG_SIM_HIGH: sim_q[TBL_W-1:TBL_W/2] <= cfg_data_i[TBL_W/2-1:0];
        CFG_WEIGHT:   wgt_q    <= cfg_data_i[WGT_W-1:0];
        CFG_ROWS_A:   rows_a_q <= cfg_data_i[ROW_W-1:0];
        CFG_ROWS_B:   rows_b_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic [MAX_ROWS-1:0] act_a, act_b;
  always_comb begin
    for (int k = 0; k < MAX_ROWS; k++) begin
      act_a[k] = (ROW_W'(k) < rows_a_q);
      act_b[k] = (ROW_W'(k) < rows_b_q);
    end
  end

  logic signed [LSUM_W-1:0] lsum [MAX_ROWS];
  logic [LCNT_W-1:0]        lcnt [MAX_ROWS];

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_lane
    csc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .sym_a_i (col_a_i[k*SYM_W +: SYM_W]),
      .act_a_i (act_a[k]),
      .col_b_i (col_b_i),
      .act_b_i (act_b),
      .sim_i   (sim_q),
      .sum_o   (lsum[k]),
      .cnt_o   (lcnt[k])
    );
  end

  logic              v0_q, v1_q;
  logic [PROD_W-1:0] pd0_q, pu0_q, pd1_q, pu1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd0_q <= PROD_W'(down_prob_a_i) * PROD_W'(down_prob_b_i);
      pu0_q <= PROD_W'(up_prob_a_i) * PROD_W'(up_prob_b_i);
      pd1_q <= pd0_q;
      pu1_q <= pu0_q;
    end
  end

  logic [ITER-1:0]  mag;
  logic             neg;
  logic [CNT_W-1:0] pairs;

  csc_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .sum_i   (lsum),
    .cnt_i   (lcnt),
    .mag_o   (mag),
    .neg_o   (neg),
    .pairs_o (pairs)
  );

  csc_iter_t it_in, it_out;

  always_comb begin
    it_in       = '0;
    it_in.valid = v1_q;
    it_in.div_n = mag;
    it_in.pairs = pairs;
    it_in.neg   = neg;
    it_in.sq_v0 = pd1_q;
    it_in.sq_v1 = pu1_q;
  end

  csc_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (it_in),
    .out_o  (it_out)
  );

  logic                     vm_q;
  logic [RT_W-1:0]          strct_q;
  logic signed [SEQ_W-1:0]  seq_q;
  logic [CNT_W-1:0]         pairs_q;
  logic [RT_W-1:0]          roots;
  logic [MUL_W-1:0]         prod;
  logic signed [SEQ_W-1:0]  seq_d;

  always_comb begin
    roots = RT_W'(it_out.sq_q0) + RT_W'(it_out.sq_q1);
    prod  = MUL_W'(roots) * MUL_W'(wgt_q);
    if (it_out.pairs == '0) begin
      seq_d = '0;
    end else if (it_out.neg) begin
      seq_d = -($signed(SEQ_W'(it_out.div_q)) <<< 4);
    end else begin
      seq_d = $signed(SEQ_W'(it_out.div_q)) <<< 4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vm_q        <= it_out.valid;
      out_valid_o <= vm_q;
    end
  end

  logic signed [ACC_W-1:0] acc;
  assign acc = $signed(ACC_W'(strct_q)) + ACC_W'(seq_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      strct_q <= prod[MUL_W-1 -: RT_W];
      seq_q   <= seq_d;
      pairs_q <= it_out.pairs;
      pair_count_o <= pairs_q;
      if (acc > $signed(ACC_W'({1'b0, {(SCORE_W-1){1'b1}}}))) begin
        score_o <= {1'b0, {(SCORE_W-1){1'b1}}};
      end else if (acc < -$signed(ACC_W'({1'b1, {(SCORE_W-1){1'b0}}}))) begin
        score_o <= {1'b1, {(SCORE_W-1){1'b0}}};
      end else begin
        score_o <= acc[SCORE_W-1:0];
      end
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_pairs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pair_count_o <= CNT_W'(MAX_ROWS * MAX_ROWS)))
    else $error("pair count out of range");

  a_no_pairs_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pair_count_o == '0) |-> !score_o[SCORE_W-1])
    else $error("negative score without pairs");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the column-pair score block: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csc_pkg::*;

  localparam int unsigned LATENCY = ITER + 4;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MID   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [CNT_W-1:0]          pairs;
  } col_score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [COL_W-1:0] col_a_i = '0, col_b_i = '0;
  logic [PROB_W-1:0] up_prob_a_i = '0, down_prob_a_i = '0, up_prob_b_i = '0, down_prob_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SCORE_W-1:0] score_o;
  logic [CNT_W-1:0] pair_count_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SIM_LOW;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rna_column_pair_structure_score dut (.*);

  // shadow of the register file
  logic [63:0] sim_lo_q = '0, sim_hi_q = '0;
  logic [15:0] weight_q = 16'd256;
  logic [3:0]  rows_a_q = 4'd1, rows_b_q = 4'd1;

  col_score_t score_q[$];
  int unsigned errors = 0, accepted = 0, checked = 0, cycles = 0;
  bit stall_en = 1'b0, gap_en = 1'b0;
  int unsigned stall_left = 0;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [15:0] floor_sqrt(logic [31:0] v);
    longint unsigned rem, root, bitv;
    rem = v; root = 0; bitv = 64'd1 << 30;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[15:0];
  endfunction

  function automatic col_score_t column_score(logic [COL_W-1:0] ca, logic [COL_W-1:0] cb,
      logic [15:0] ua, logic [15:0] da, logic [15:0] ub, logic [15:0] db);
    col_score_t r;
    int na, nb, sum, pairs, seq;
    longint roots, strct, sc;
    logic [2:0] sa, sb;
    logic [3:0] idx;
    logic [7:0] byt;
    na = (rows_a_q > MAX_ROWS) ? MAX_ROWS : rows_a_q;
    nb = (rows_b_q > MAX_ROWS) ? MAX_ROWS : rows_b_q;
    sum = 0; pairs = 0; seq = 0;
    for (int k = 0; k < na; k++) begin
      sa = ca[3*k +: 3];
      if (sa > 3) continue;
      for (int l = 0; l < nb; l++) begin
        sb = cb[3*l +: 3];
        if (sb > 3) continue;
        idx = {sa[1:0], sb[1:0]};
        byt = idx[3] ? sim_hi_q[8*idx[2:0] +: 8] : sim_lo_q[8*idx[2:0] +: 8];
        sum += int'($signed(byt));
        pairs++;
      end
    end
    if (pairs != 0) seq = (sum / pairs) * 16;
    roots = longint'(floor_sqrt(da * db)) + longint'(floor_sqrt(ua * ub));
    strct = (roots * longint'(weight_q)) >>> 16;
    sc = strct + seq;
    if (sc > 524287) sc = 524287;
    if (sc < -524288) sc = -524288;
    r.score = sc[SCORE_W-1:0];
    r.pairs = pairs[CNT_W-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    col_score_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rna_column_pair_structure_score verification failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (score_q.size() == 0) begin
        $error("unexpected result score=%0d pair_count=%0d", score_o, pair_count_o);
        errors++;
      end else begin
        e = score_q.pop_front();
        checked++;
        if (score_o !== e.score) begin
          $error("score expected %0d actual %0d", e.score, score_o);
          errors++;
        end
        if (pair_count_o !== e.pairs) begin
          $error("pair_count expected %0d actual %0d", e.pairs, pair_count_o);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (stall_en && r < 20) begin
        stall_left = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [COL_W-1:0] ca, logic [COL_W-1:0] cb,
      logic [15:0] ua, logic [15:0] da, logic [15:0] ub, logic [15:0] db);
    int unsigned r, gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    col_a_i = ca; col_b_i = cb;
    up_prob_a_i = ua; down_prob_a_i = da; up_prob_b_i = ub; down_prob_b_i = db;
    do @(posedge clk_i); while (in_stall_o);
    score_q.push_back(column_score(ca, cb, ua, da, ub, db));
    accepted++;
    r = $urandom_range(0, 99);
    if (gap_en && r < 30) begin
      gap = (r < 3) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SIM_LOW:  sim_lo_q = val;
      CFG_SIM_HIGH: sim_hi_q = val;
      CFG_WEIGHT:   weight_q = val[15:0];
      CFG_ROWS_A:   rows_a_q = val[3:0];
      CFG_ROWS_B:   rows_b_q = val[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [COL_W-1:0] rand_column();
    logic [COL_W-1:0] c;
    for (int k = 0; k < MAX_ROWS; k++)
      c[3*k +: 3] = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3)) : 3'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_defaults();
    send_item('0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item('1, '1, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF);
    wait_drain();
  endtask

  task automatic test_directed();
    write_reg(CFG_SIM_LOW, 64'h7F7F_7F7F_7F7F_7F7F);
    write_reg(CFG_SIM_HIGH, 64'h7F7F_7F7F_7F7F_7F7F);
    write_reg(CFG_WEIGHT, 16'hFFFF);
    write_reg(CFG_ROWS_A, 8);
    write_reg(CFG_ROWS_B, 8);
    send_item('0, 24'h6DB6DB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(24'h924924, 24'hFFFFFF, 0, 0, 0, 0);
    wait_drain();
    write_reg(CFG_SIM_LOW, 64'h8080_8080_8080_8080);
    write_reg(CFG_SIM_HIGH, 64'h8080_8080_8080_8080);
    write_reg(CFG_WEIGHT, 0);
    send_item('0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(24'h0000FF, 24'hFAC688, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000);
    wait_drain();
    // row counts of zero and above the maximum
    write_reg(CFG_ROWS_A, 0);
    send_item('0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_drain();
    write_reg(CFG_ROWS_A, 15);
    write_reg(CFG_ROWS_B, 0);
    send_item('0, '0, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0);
    wait_drain();
    write_reg(CFG_ROWS_B, 9);
    write_reg(CFG_SIM_LOW, 64'hF00F_1E2D_3C4B_5A69);
    write_reg(CFG_SIM_HIGH, 64'h8877_6655_4433_2211);
    write_reg(CFG_WEIGHT, 16'h0180);
    for (int i = 0; i < 16; i++) send_item({8{3'(i % 4)}}, {8{3'(i / 4)}}, 0, 0, 0, 0);
    wait_drain();
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED_FIRST, '1);
    write_reg(CFG_UNUSED_LAST, '1);
    write_reg(CFG_UNUSED_MID, '1);
    send_item(24'h053977, 24'h0FAC68, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001);
    wait_drain();
  endtask

  task automatic test_random();
    gap_en = 1'b1;
    stall_en = 1'b1;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_SIM_LOW, {$urandom, $urandom});
      write_reg(CFG_SIM_HIGH, {$urandom, $urandom});
      write_reg(CFG_WEIGHT, (ph == 3) ? 16'hFFFF : (ph == 4) ? 16'h0 : 16'($urandom));
      write_reg(CFG_ROWS_A, (ph == 5) ? 4'd15 : 4'($urandom_range(0, 9)));
      write_reg(CFG_ROWS_B, (ph == 6) ? 4'd8 : 4'($urandom_range(0, 9)));
      gap_en = (ph % 4 != 1);
      stall_en = (ph % 4 != 2);
      for (int i = 0; i < 120; i++) begin
        if (i == 60) wait_drain();
        if ($urandom_range(0, 9) == 0)
          send_item(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
        else
          send_item(rand_column(), rand_column(), rand_prob(), rand_prob(),
                    rand_prob(), rand_prob());
      end
      wait_drain();
    end
    stall_en = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_directed();
    test_unused_index();
    test_random();
    wait_drain();
    $display("covered %0d requests over directed extremes and 12 random register settings,",
             accepted);
    $display("with random gaps and back-pressure; %0d results checked", checked);
    if (errors == 0 && score_q.size() == 0) begin
      $display("rna_column_pair_structure_score verification clean");
    end else begin
      $display("rna_column_pair_structure_score verification failed");
    end
    $finish;
  end

endmodule

// File: rna_column_pair_structure_score.f
rtl/core/csc_pkg.sv
rtl/core/csc_lane.sv
rtl/core/csc_merge.sv
rtl/core/csc_iter.sv
rtl/core/rna_column_pair_structure_score.sv
tb/tb_top.sv
